// File: src/bsbd_pkg.sv
// Shared types, target codes and constants for the bank switch bus decoder.
package bsbd_pkg;

	localparam int COLOUR_WORDS_DEF = 1024;

	localparam logic [3:0] T_PORT     = 4'd0;
	localparam logic [3:0] T_RAM      = 4'd1;
	localparam logic [3:0] T_BASIC    = 4'd2;
	localparam logic [3:0] T_CHARSET  = 4'd3;
	localparam logic [3:0] T_KERNAL   = 4'd4;
	localparam logic [3:0] T_VIDEO    = 4'd5;
	localparam logic [3:0] T_SOUND    = 4'd6;
	localparam logic [3:0] T_COLOUR   = 4'd7;
	localparam logic [3:0] T_TIMER1   = 4'd8;
	localparam logic [3:0] T_TIMER2   = 4'd9;
	localparam logic [3:0] T_UNMAPPED = 4'd10;

	localparam logic [1:0] CFG_BASIC   = 2'd0;
	localparam logic [1:0] CFG_KERNAL  = 2'd1;
	localparam logic [1:0] CFG_CHARSET = 2'd2;

	localparam logic [7:0] PORT_DIR_RST   = 8'h2F;
	localparam logic [7:0] PORT_LATCH_RST = 8'h37;
	localparam logic [7:0] PORT_FLT_RST   = 8'hFF;

	typedef enum logic [2:0] {
		LS_NONE,
		LS_DIR,
		LS_PINS,
		LS_COLOUR,
		LS_HIGH
	} lsel_t;

	typedef struct packed {
		logic       wr_dir;
		logic       wr_latch;
		logic [7:0] data;
	} port_upd_t;

	typedef struct packed {
		logic [3:0]  target;
		logic [15:0] taddr;
		logic        fwd;
		lsel_t       lsel;
		logic        wr_dir;
		logic        wr_latch;
		logic        colour_wr;
		logic        colour_rd;
	} decode_t;

endpackage

// File: src/bsbd_port.sv
// On-chip processor port: direction, latch, floating-bit memory and pin readback.
module bsbd_port (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bsbd_pkg::port_upd_t  upd,
	output logic [7:0]           direction,
	output logic [7:0]           latch,
	output logic [7:0]           pins
);
	import bsbd_pkg::*;

	logic [7:0] dir_q;
	logic [7:0] latch_q;
	logic [7:0] flt_q;
	logic [7:0] going;
	logic [7:0] pins_raw;

	assign going = dir_q & ~upd.data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q   <= PORT_DIR_RST;
			latch_q <= PORT_LATCH_RST;
			flt_q   <= PORT_FLT_RST;
		end else if (upd.wr_dir) begin
			flt_q <= (flt_q & ~going) | (latch_q & going);
			dir_q <= upd.data;
		end else if (upd.wr_latch) begin
			flt_q   <= (flt_q & ~dir_q) | (upd.data & dir_q);
			latch_q <= upd.data;
		end
	end

	always_comb begin
		pins_raw = (latch_q & dir_q) | ((~dir_q | latch_q) & 8'h37) |
			(flt_q & ~dir_q & 8'hC8);
		pins = pins_raw;
		if (!dir_q[5]) begin
			pins[5] = 1'b0;
		end
	end

	assign direction = dir_q;
	assign latch     = latch_q;

endmodule

// File: src/bsbd_colour_ram.sv
// Colour RAM: 4-bit words, one write or one registered read per cycle.
module bsbd_colour_ram #(
	parameter int COLOUR_WORDS = bsbd_pkg::COLOUR_WORDS_DEF
) (
	input  logic        clk,
	input  logic        wr_en,
	input  logic        rd_en,
	input  logic [15:0] addr,
	input  logic [3:0]  wdata,
	output logic [3:0]  rdata
);
	import bsbd_pkg::*;

	localparam int IDX_W = $clog2(COLOUR_WORDS);

	logic [3:0]       mem [COLOUR_WORDS];
	logic [15:0]      offset;
	logic [IDX_W-1:0] idx;
	logic [3:0]       rdata_q;

	assign offset = addr - 16'hD800;
	assign idx    = offset[IDX_W-1:0];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[idx] <= wdata;
		end
		if (rd_en) begin
			rdata_q <= mem[idx];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: src/bsbd_decode.sv
// Address decode of one bus access into target, address, local answer and port updates.
module bsbd_decode #(
	parameter int COLOUR_WORDS = bsbd_pkg::COLOUR_WORDS_DEF
) (
	input  logic              func,
	input  logic [15:0]       addr,
	input  logic [7:0]        latch,
	input  logic              basic_present,
	input  logic              kernal_present,
	input  logic              charset_present,
	output bsbd_pkg::decode_t dec
);
	import bsbd_pkg::*;

	localparam logic [16:0] COL_END = 17'h0D7FF + 17'(COLOUR_WORDS);

	logic io_vis;

	assign io_vis = (addr[15:12] == 4'hD) && latch[2];

	always_comb begin
		dec        = '0;
		dec.target = T_RAM;
		dec.taddr  = addr;
		dec.lsel   = LS_NONE;
		priority if (addr[15:1] == 15'd0) begin
			dec.target = T_PORT;
			if (!func) begin
				dec.lsel = addr[0] ? LS_PINS : LS_DIR;
			end else if (!addr[0]) begin
				dec.wr_dir = 1'b1;
			end else begin
				dec.wr_latch = 1'b1;
			end
		end else if (io_vis) begin
			priority if (addr <= 16'hD3FF) begin
				dec.target = T_VIDEO;
				dec.fwd    = func;
			end else if (addr <= 16'hD7FF) begin
				dec.target = T_SOUND;
				dec.fwd    = func;
			end else if ({1'b0, addr} <= COL_END) begin
				dec.target    = T_COLOUR;
				dec.colour_wr = func;
				dec.colour_rd = !func;
				dec.lsel      = func ? LS_NONE : LS_COLOUR;
			end else if (addr[15:8] == 8'hDC) begin
				dec.target = T_TIMER1;
				dec.fwd    = func;
			end else if (addr[15:8] == 8'hDD) begin
				dec.target = T_TIMER2;
				dec.fwd    = func;
			end else begin
				dec.target = T_UNMAPPED;
				dec.lsel   = func ? LS_NONE : LS_HIGH;
			end
		end else if (func) begin
			dec.fwd = 1'b1;
		end else if (addr[15:13] == 3'b101) begin
			if (latch[0] && basic_present) begin
				dec.target = T_BASIC;
				dec.taddr  = {3'b000, addr[12:0]};
			end
		end else if (addr[15:12] == 4'hD) begin
			if (charset_present) begin
				dec.target = T_CHARSET;
				dec.taddr  = {4'h0, addr[11:0]};
			end
		end else if (addr[15:13] == 3'b111) begin
			if (latch[1] && kernal_present) begin
				dec.target = T_KERNAL;
				dec.taddr  = {3'b000, addr[12:0]};
			end
		end
	end

endmodule

// File: src/bank_switch_bus_decoder.sv
// Top level of the bank switch bus decoder: input register, decode, result register.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid/in_ready, func, bus_address,     | to block
//          | write_byte                                |
//  out     | out_valid/out_ready, target,              | from block
//          | target_address, local_valid, local_byte,  |
//          | forward_write, forward_byte               |
//  cfg     | cfg_write, cfg_index, cfg_data            | to block
//
// One word per cycle unless stalled; words pass the input, then the result register.
// Port state and colour RAM update as a word moves from the input register
// to the result register, so each word sees every earlier word's effect.
// Reset sets the port to its power-up values; the colour RAM is not cleared.
// A stalled result register holds and backs up into the input register.
module bank_switch_bus_decoder #(
	parameter int COLOUR_WORDS = bsbd_pkg::COLOUR_WORDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        func,
	input  logic [15:0] bus_address,
	input  logic [7:0]  write_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  target,
	output logic [15:0] target_address,
	output logic        local_valid,
	output logic [7:0]  local_byte,
	output logic        forward_write,
	output logic [7:0]  forward_byte,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic        cfg_data
);
	import bsbd_pkg::*;

	logic        basic_q;
	logic        kernal_q;
	logic        charset_q;

	logic        valid_s1;
	logic        func_s1;
	logic [15:0] addr_s1;
	logic [7:0]  data_s1;

	logic        valid_s2;
	logic [3:0]  target_s2;
	logic [15:0] taddr_s2;
	lsel_t       lsel_s2;
	logic [7:0]  lbyte_s2;
	logic        fwd_s2;
	logic [7:0]  fbyte_s2;

	logic        accept;
	logic        open_s2;
	logic        advance;
	decode_t     dec;
	port_upd_t   upd;
	logic [7:0]  port_dir;
	logic [7:0]  port_latch;
	logic [7:0]  port_pins;
	logic [3:0]  colour_rd;
	logic [7:0]  lbyte_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			basic_q   <= 1'b0;
			kernal_q  <= 1'b0;
			charset_q <= 1'b0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_BASIC:   basic_q   <= cfg_data;
				CFG_KERNAL:  kernal_q  <= cfg_data;
				CFG_CHARSET: charset_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign open_s2  = !valid_s2 || out_ready;
	assign advance  = valid_s1 && open_s2;
	assign in_ready = !valid_s1 || open_s2;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1 <= func;
			addr_s1 <= bus_address;
			data_s1 <= write_byte;
		end
	end

	bsbd_decode #(
		.COLOUR_WORDS(COLOUR_WORDS)
	) u_decode (
		.func           (func_s1),
		.addr           (addr_s1),
		.latch          (port_latch),
		.basic_present  (basic_q),
		.kernal_present (kernal_q),
		.charset_present(charset_q),
		.dec            (dec)
	);

	assign upd.wr_dir   = advance && dec.wr_dir;
	assign upd.wr_latch = advance && dec.wr_latch;
	assign upd.data     = data_s1;

	bsbd_port u_port (
		.clk      (clk),
		.arst_n   (arst_n),
		.upd      (upd),
		.direction(port_dir),
		.latch    (port_latch),
		.pins     (port_pins)
	);

	bsbd_colour_ram #(
		.COLOUR_WORDS(COLOUR_WORDS)
	) u_colour (
		.clk  (clk),
		.wr_en(advance && dec.colour_wr),
		.rd_en(advance && dec.colour_rd),
		.addr (addr_s1),
		.wdata(data_s1[3:0]),
		.rdata(colour_rd)
	);

	always_comb begin
		unique case (dec.lsel)
			LS_DIR:  lbyte_next = port_dir;
			LS_PINS: lbyte_next = port_pins;
			LS_HIGH: lbyte_next = addr_s1[15:8];
			default: lbyte_next = 8'h00;
		endcase
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			target_s2 <= dec.target;
			taddr_s2  <= dec.taddr;
			lsel_s2   <= dec.lsel;
			lbyte_s2  <= lbyte_next;
			fwd_s2    <= dec.fwd;
			fbyte_s2  <= dec.fwd ? data_s1 : 8'h00;
		end
	end

	assign out_valid      = valid_s2;
	assign target         = target_s2;
	assign target_address = taddr_s2;
	assign local_valid    = (lsel_s2 != LS_NONE);
	assign local_byte     = (lsel_s2 == LS_COLOUR) ? {4'hF, colour_rd} : lbyte_s2;
	assign forward_write  = fwd_s2;
	assign forward_byte   = fbyte_s2;

	a_local_or_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(local_valid && forward_write))
		else $error("local answer and forwarded write together");

	a_fwd_target: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && forward_write) |->
		(target != T_PORT && target != T_COLOUR && target != T_UNMAPPED))
		else $error("forwarded write to a locally handled target");

	a_dir_write: assert property (@(posedge clk) disable iff (!arst_n)
		upd.wr_dir |=> (port_dir == $past(data_s1)))
		else $error("direction register missed a write");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !in_ready) |=> (valid_s1 && $stable(addr_s1)))
		else $error("input register changed while stalled");

endmodule

// File: tb/bank_switch_bus_decoder_test.sv
// Self-checking testbench for the bank switch bus decoder: port, banking and colour RAM decode.
module bank_switch_bus_decoder_test;
	import bsbd_pkg::*;

	localparam logic [1:0] CFG_NONE = 2'd3;
	localparam int RANDOM_PER_SETTING = 144;

	typedef struct packed {
		logic        wr;
		logic [15:0] addr;
		logic [7:0]  data;
		logic        drain_first;
	} bus_access_t;

	typedef struct packed {
		logic [3:0]  target;
		logic [15:0] taddr;
		logic        lvalid;
		logic [7:0]  lbyte;
		logic        fwd;
		logic [7:0]  fbyte;
	} decode_res_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        func = 1'b0;
	logic [15:0] bus_address = 16'h0000;
	logic [7:0]  write_byte = 8'h00;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [3:0]  target;
	logic [15:0] target_address;
	logic        local_valid;
	logic [7:0]  local_byte;
	logic        forward_write;
	logic [7:0]  forward_byte;
	logic        cfg_write = 1'b0;
	logic [1:0]  cfg_index = 2'd0;
	logic        cfg_data = 1'b0;

	bank_switch_bus_decoder u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.bus_address(bus_address),
		.write_byte(write_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.target(target),
		.target_address(target_address),
		.local_valid(local_valid),
		.local_byte(local_byte),
		.forward_write(forward_write),
		.forward_byte(forward_byte),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predictor state
	logic [7:0] port_dir = PORT_DIR_RST;
	logic [7:0] port_lat = PORT_LATCH_RST;
	logic [7:0] port_flt = PORT_FLT_RST;
	logic [3:0] colour_mem [1024];
	logic       basic_on = 1'b0;
	logic       kernal_on = 1'b0;
	logic       charset_on = 1'b0;

	// generator state
	logic [7:0] gen_latch = PORT_LATCH_RST;
	bit         colour_seen [1024];

	bus_access_t pending_accesses [$];
	decode_res_t expected_decodes [$];

	bus_access_t cur_access;
	decode_res_t drv_pred, mon_got, mon_want;
	bit          idle_on = 1'b1;
	bit          hold_done = 1'b0;
	int          send_gap = 0;
	int          recv_gap = 0;
	int          long_hold = 0;
	int          seen_count = 0;
	int          mismatch_count = 0;
	int          orphan_count = 0;
	int          target_hits [16];

	function automatic logic [7:0] port_pins();
		logic [7:0] r;
		r = (port_lat & port_dir) | ((~port_dir | port_lat) & 8'h37) |
			(port_flt & ~port_dir & 8'hC8);
		if (!port_dir[5])
			r[5] = 1'b0;
		return r;
	endfunction

	task automatic decode_access(input bus_access_t acc, output decode_res_t res);
		logic [7:0]  going;
		logic [15:0] a;
		a = acc.addr;
		res = '0;
		res.target = T_RAM;
		res.taddr = a;
		if (a == 16'h0000 || a == 16'h0001) begin
			res.target = T_PORT;
			if (!acc.wr) begin
				res.lvalid = 1'b1;
				res.lbyte = (a == 16'h0000) ? port_dir : port_pins();
			end else if (a == 16'h0000) begin
				going = port_dir & ~acc.data;
				port_flt = (port_flt & ~going) | (port_lat & going);
				port_dir = acc.data;
			end else begin
				port_flt = (port_flt & ~port_dir) | (acc.data & port_dir);
				port_lat = acc.data;
			end
		end else if (a[15:12] == 4'hD && port_lat[2]) begin
			if (a <= 16'hD3FF) begin
				res.target = T_VIDEO;
				res.fwd = acc.wr;
			end else if (a <= 16'hD7FF) begin
				res.target = T_SOUND;
				res.fwd = acc.wr;
			end else if (a <= 16'hDBFF) begin
				res.target = T_COLOUR;
				if (acc.wr) begin
					colour_mem[a[9:0]] = acc.data[3:0];
				end else begin
					res.lvalid = 1'b1;
					res.lbyte = {4'hF, colour_mem[a[9:0]]};
				end
			end else if (a[11:8] == 4'hC) begin
				res.target = T_TIMER1;
				res.fwd = acc.wr;
			end else if (a[11:8] == 4'hD) begin
				res.target = T_TIMER2;
				res.fwd = acc.wr;
			end else begin
				res.target = T_UNMAPPED;
				if (!acc.wr) begin
					res.lvalid = 1'b1;
					res.lbyte = a[15:8];
				end
			end
		end else if (acc.wr) begin
			res.fwd = 1'b1;
		end else if (a[15:13] == 3'b101) begin
			if (port_lat[0] && basic_on) begin
				res.target = T_BASIC;
				res.taddr = a - 16'hA000;
			end
		end else if (a[15:12] == 4'hD) begin
			if (charset_on) begin
				res.target = T_CHARSET;
				res.taddr = a - 16'hD000;
			end
		end else if (a[15:13] == 3'b111) begin
			if (port_lat[1] && kernal_on) begin
				res.target = T_KERNAL;
				res.taddr = a - 16'hE000;
			end
		end
		if (res.fwd)
			res.fbyte = acc.data;
	endtask

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				decode_access(cur_access, drv_pred);
				expected_decodes.push_back(drv_pred);
				if (idle_on && $urandom_range(0, 5) == 0)
					send_gap = $urandom_range(1, 11);
			end
			if (!in_valid || in_ready) begin
				if (send_gap != 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pending_accesses.size() != 0 &&
						!(pending_accesses[0].drain_first && expected_decodes.size() != 0)) begin
					cur_access = pending_accesses.pop_front();
					in_valid <= 1'b1;
					func <= cur_access.wr;
					bus_address <= cur_access.addr;
					write_byte <= cur_access.data;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				mon_got.target = target;
				mon_got.taddr = target_address;
				mon_got.lvalid = local_valid;
				mon_got.lbyte = local_byte;
				mon_got.fwd = forward_write;
				mon_got.fbyte = forward_byte;
				if (expected_decodes.size() == 0) begin
					orphan_count++;
					if (mismatch_count + orphan_count <= 10)
						$display("word %0d: unexpected result target %0d addr %h",
							seen_count, target, target_address);
				end else begin
					mon_want = expected_decodes.pop_front();
					if (mon_got !== mon_want) begin
						mismatch_count++;
						if (mismatch_count + orphan_count <= 10) begin
							$display("word %0d: expected tgt %0d adr %h lv %b lb %h fw %b fb %h",
								seen_count, mon_want.target, mon_want.taddr, mon_want.lvalid,
								mon_want.lbyte, mon_want.fwd, mon_want.fbyte);
							$display("word %0d: actual   tgt %0d adr %h lv %b lb %h fw %b fb %h",
								seen_count, mon_got.target, mon_got.taddr, mon_got.lvalid,
								mon_got.lbyte, mon_got.fwd, mon_got.fbyte);
						end
					end
				end
				target_hits[target]++;
				seen_count++;
			end
			if (!hold_done && seen_count >= 400) begin
				hold_done = 1'b1;
				long_hold = 90;
			end
			if (long_hold != 0) begin
				long_hold--;
				out_ready <= 1'b0;
			end else if (recv_gap != 0) begin
				recv_gap--;
				out_ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 6) == 0) begin
				recv_gap = $urandom_range(1, 11) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic queue_access(input logic wr, input logic [15:0] a, input logic [7:0] d,
			input logic drain);
		bus_access_t acc;
		// turn a read of a never-written colour entry into a write
		if (gen_latch[2] && a >= 16'hD800 && a <= 16'hDBFF) begin
			if (!wr && !colour_seen[a[9:0]])
				wr = 1'b1;
			if (wr)
				colour_seen[a[9:0]] = 1'b1;
		end
		if (wr && a == 16'h0001)
			gen_latch = d;
		acc.wr = wr;
		acc.addr = a;
		acc.data = d;
		acc.drain_first = drain;
		pending_accesses.push_back(acc);
	endtask

	task automatic queue_random(input logic drain);
		int          sel;
		logic        wr;
		logic [15:0] a;
		logic [7:0]  d;
		sel = $urandom_range(0, 99);
		wr = 1'($urandom_range(0, 1));
		d = 8'($urandom_range(0, 255));
		if (sel < 12)
			a = 16'($urandom_range(0, 1));
		else if (sel < 24)
			a = 16'($urandom_range(16'hD800, 16'hDBFF));
		else if (sel < 44)
			a = 16'($urandom_range(16'hD000, 16'hDFFF));
		else if (sel < 56)
			a = 16'($urandom_range(16'hA000, 16'hBFFF));
		else if (sel < 68)
			a = 16'($urandom_range(16'hE000, 16'hFFFF));
		else
			a = 16'($urandom_range(0, 16'hFFFF));
		// keep I/O visible most of the time
		if (wr && a == 16'h0001 && $urandom_range(0, 3) != 0)
			d[2] = 1'b1;
		queue_access(wr, a, d, drain);
		if (wr && a[15:10] == 6'b110110 && $urandom_range(0, 2) == 0)
			queue_access(1'b0, a, 8'h00, 1'b0);
		else if (wr && a <= 16'h0001 && $urandom_range(0, 1) == 0)
			queue_access(1'b0, 16'h0001, 8'h00, 1'b0);
	endtask

	task automatic wait_idle();
		while (pending_accesses.size() != 0 || in_valid || expected_decodes.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic val);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (idx)
			CFG_BASIC: basic_on = val;
			CFG_KERNAL: kernal_on = val;
			CFG_CHARSET: charset_on = val;
			default: ;
		endcase
	endtask

	task automatic set_roms(input logic [2:0] bits);
		write_reg(CFG_BASIC, bits[0]);
		write_reg(CFG_KERNAL, bits[1]);
		write_reg(CFG_CHARSET, bits[2]);
	endtask

	initial begin
		#4000000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		set_roms(3'b111);
		write_reg(CFG_NONE, 1'b1);

		queue_access(1'b0, 16'h0000, 8'h00, 1'b0);
		queue_access(1'b0, 16'h0001, 8'h00, 1'b0);
		queue_access(1'b1, 16'h0000, 8'h00, 1'b0);
		queue_access(1'b0, 16'h0001, 8'h00, 1'b0);
		queue_access(1'b1, 16'h0000, 8'hFF, 1'b0);
		queue_access(1'b1, 16'h0001, 8'h00, 1'b0);
		queue_access(1'b0, 16'h0001, 8'h00, 1'b0);
		queue_access(1'b0, 16'hA000, 8'h00, 1'b0);
		queue_access(1'b1, 16'h0001, 8'hFF, 1'b0);
		queue_access(1'b0, 16'h0001, 8'h00, 1'b0);
		queue_access(1'b1, 16'h0000, 8'h2F, 1'b0);
		queue_access(1'b1, 16'h0001, 8'h37, 1'b0);
		queue_access(1'b0, 16'hBFFF, 8'h00, 1'b0);
		queue_access(1'b0, 16'hFFFF, 8'h00, 1'b0);
		queue_access(1'b1, 16'hE000, 8'hA5, 1'b0);
		queue_access(1'b1, 16'hD800, 8'hFF, 1'b0);
		queue_access(1'b0, 16'hD800, 8'h00, 1'b0);
		queue_access(1'b1, 16'hDBFF, 8'h5A, 1'b0);
		queue_access(1'b0, 16'hDBFF, 8'h00, 1'b0);
		queue_access(1'b1, 16'hD000, 8'h81, 1'b0);
		queue_access(1'b1, 16'hD7FF, 8'h7E, 1'b0);
		queue_access(1'b0, 16'hDC00, 8'h00, 1'b0);
		queue_access(1'b1, 16'hDDFF, 8'hC3, 1'b0);
		queue_access(1'b0, 16'hDE00, 8'h00, 1'b0);
		queue_access(1'b1, 16'hDFFF, 8'h3C, 1'b0);
		queue_access(1'b1, 16'h0001, 8'h33, 1'b0);
		queue_access(1'b0, 16'hDFFF, 8'h00, 1'b0);
		queue_access(1'b1, 16'hD000, 8'h99, 1'b0);
		queue_access(1'b1, 16'h0001, 8'h37, 1'b0);
		wait_idle();

		for (int p = 0; p < 8; p++) begin
			idle_on = (p != 7);
			set_roms(p[2:0]);
			for (int i = 0; i < RANDOM_PER_SETTING; i++)
				queue_random(p == 3 && i == 80);
			wait_idle();
		end
		repeat (8) @(posedge clk);

		$display("Decoded %0d bus words across all 8 ROM settings with port and colour RAM state",
			seen_count);
		$display("Targets: port %0d ram %0d basic %0d char %0d kernal %0d io %0d unmapped %0d",
			target_hits[T_PORT], target_hits[T_RAM], target_hits[T_BASIC],
			target_hits[T_CHARSET], target_hits[T_KERNAL],
			target_hits[T_VIDEO] + target_hits[T_SOUND] + target_hits[T_COLOUR] +
			target_hits[T_TIMER1] + target_hits[T_TIMER2], target_hits[T_UNMAPPED]);
		if (mismatch_count == 0 && orphan_count == 0 && expected_decodes.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
